// ----- sv/wg_pkg.sv -----
// shared constants, types and the quarter sine table function for the waveform generator
package wg_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int AMP_BITS    = 15;
    localparam int INC_BITS    = 32;
    localparam int PERIOD_BITS = 24;
    localparam int MODE_BITS   = 3;
    localparam int CFG_BITS    = 32;
    localparam int IDX_BITS    = 2;
    localparam int TBL_BITS    = 16;

    localparam int FULL_SCALE  = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int HALF_FS     = FULL_SCALE / 2;

    localparam logic [MODE_BITS-1:0] MODE_SINE    = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_SQUARE  = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_SAW     = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_TRIANGLE = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_IMPULSE = 3'd4;

    localparam logic [IDX_BITS-1:0] REG_MODE   = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_INC    = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_AMP    = 2'd2;
    localparam logic [IDX_BITS-1:0] REG_PERIOD = 2'd3;

    localparam longint unsigned PIH_Q30 = 64'd1686629713;
    localparam longint ONE_Q30 = 64'sd1073741824;

    typedef struct packed {
        logic peak;
        logic neg;
        logic cnt_zero;
        logic last;
    } wg_flags_t;

    // shift and subtract quotient, only evaluated while building the table
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        int b;
        quo = '0;
        rem = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sin(pi/2 * k / 2^addr_bits) in Q30 by Taylor series, scaled to full scale
    function automatic logic [TBL_BITS-1:0] quarter_entry(input int unsigned k,
                                                          input int unsigned addr_bits);
        longint unsigned x;
        longint unsigned term;
        longint unsigned sq;
        longint unsigned den;
        longint sum;
        longint unsigned scaled;
        int unsigned i;
        x = (PIH_Q30 * longint'(k)) >> addr_bits;
        term = x;
        sum = longint'(x);
        sq = (x * x) >> 30;
        for (i = 1; i <= 8; i++) begin
            term = (term * sq) >> 30;
            den = longint'(4 * i * i + 2 * i);
            term = div_u64(term, den);
            if (i[0]) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > ONE_Q30) begin
            sum = ONE_Q30;
        end
        scaled = (longint'(sum) * longint'(FULL_SCALE) + (64'd1 << 29)) >> 30;
        return scaled[TBL_BITS-1:0];
    endfunction

endpackage

// ----- sv/wg_ram.sv -----
// generic single write port ram with registered read
module wg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/wg_tbl_init.sv -----
// loads the quarter sine table into ram after reset, one entry per cycle
module wg_tbl_init #(
    parameter int ADDR_BITS = 10
) (
    input  logic                         clk,
    input  logic                         rstn,
    output logic                         we,
    output logic [ADDR_BITS-1:0]         waddr,
    output logic [wg_pkg::TBL_BITS-1:0]  wdata,
    output logic                         done
);
    import wg_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [TBL_BITS-1:0]  rom [DEPTH];
    logic [ADDR_BITS:0]   cnt_reg;
    logic [ADDR_BITS:0]   cnt_next;
    logic                 we_reg;
    logic                 we_next;
    logic [ADDR_BITS-1:0] waddr_reg;
    logic [TBL_BITS-1:0]  wdata_reg;

    for (genvar g = 0; g < DEPTH; g++) begin : g_rom
        localparam logic [TBL_BITS-1:0] ENTRY = quarter_entry(g, ADDR_BITS);
        assign rom[g] = ENTRY;
    end

    always_comb begin
        we_next  = !cnt_reg[ADDR_BITS];
        cnt_next = we_next ? cnt_reg + 1'b1 : cnt_reg;
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            cnt_reg <= '0;
            we_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            we_reg  <= we_next;
        end
    end

    always_ff @(posedge clk) begin
        waddr_reg <= cnt_reg[ADDR_BITS-1:0];
        wdata_reg <= rom[cnt_reg[ADDR_BITS-1:0]];
    end

    assign we    = we_reg;
    assign waddr = waddr_reg;
    assign wdata = wdata_reg;
    assign done  = cnt_reg[ADDR_BITS] && !we_reg;

endmodule

// ----- sv/wg_nco.sv -----
// phase accumulator and impulse counter
module wg_nco #(
    parameter int PHASE_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rstn,
    input  logic                           accept,
    input  logic                           restart,
    input  logic [wg_pkg::INC_BITS-1:0]    inc,
    input  logic [wg_pkg::PERIOD_BITS-1:0] period,
    output logic [PHASE_BITS-1:0]          phase,
    output logic                           cnt_zero
);
    import wg_pkg::*;

    logic [PHASE_BITS-1:0]  phase_reg;
    logic [PHASE_BITS-1:0]  phase_next;
    logic [PERIOD_BITS-1:0] cnt_reg;
    logic [PERIOD_BITS-1:0] cnt_next;
    logic [PERIOD_BITS-1:0] cnt_cur;
    logic [PERIOD_BITS-1:0] cnt_inc;
    logic [PERIOD_BITS-1:0] period_eff;

    always_comb begin
        phase      = restart ? '0 : phase_reg;
        cnt_cur    = restart ? '0 : cnt_reg;
        cnt_zero   = (cnt_cur == '0);
        phase_next = phase + PHASE_BITS'(inc);
        cnt_inc    = cnt_cur + 1'b1;
        period_eff = (period == '0) ? PERIOD_BITS'(1) : period;
        cnt_next   = (cnt_inc >= period_eff) ? '0 : cnt_inc;
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            phase_reg <= '0;
            cnt_reg   <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- sv/wg_shape.sv -----
// amplitude multiply stage and waveform select stage feeding the output register
module wg_shape #(
    parameter int PHASE_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rstn,
    input  logic                          adv,
    input  logic                          v0,
    input  logic [PHASE_BITS-1:0]         p0,
    input  wg_pkg::wg_flags_t             flags0,
    input  logic [wg_pkg::TBL_BITS-1:0]   rdata,
    input  logic [wg_pkg::MODE_BITS-1:0]  mode,
    input  logic [wg_pkg::AMP_BITS-1:0]   amp,
    output logic                          m_valid,
    output logic [wg_pkg::SAMPLE_BITS-1:0] m_sample,
    output logic                          m_last
);
    import wg_pkg::*;

    localparam int PROD_BITS = AMP_BITS + PHASE_BITS;
    localparam logic [PROD_BITS:0] SAW_RND = (PROD_BITS + 1)'(1) << (PHASE_BITS - 2);
    localparam logic [PROD_BITS:0] TRI_RND = (PROD_BITS + 1)'(1) << (PHASE_BITS - 3);

    // multiply stage
    logic [AMP_BITS-1:0]   s_val;
    logic [PHASE_BITS-1:0] tri_d;
    logic [PHASE_BITS-1:0] op;
    logic [PROD_BITS-1:0]  prod_next;
    logic                  v1_reg;
    logic [PROD_BITS-1:0]  prod1_reg;
    logic                  msb1_reg;
    wg_flags_t             flags1_reg;

    // select stage
    logic [30:0]           sin_x;
    logic [31:0]           sin_q;
    logic signed [16:0]    mag;
    logic signed [16:0]    amp_s;
    logic [PROD_BITS:0]    saw_sum;
    logic [PROD_BITS:0]    saw_q;
    logic [PROD_BITS:0]    tri_sum;
    logic [PROD_BITS:0]    tri_q;
    logic signed [16:0]    smp;
    logic                  v2_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                  last_reg;

    always_comb begin
        s_val = flags0.peak ? AMP_BITS'(FULL_SCALE) : rdata[AMP_BITS-1:0];
        tri_d = p0[PHASE_BITS-1] ? ('0 - p0) : p0;
        case (mode)
            MODE_SINE:     op = PHASE_BITS'(s_val);
            MODE_TRIANGLE: op = tri_d;
            default:       op = p0;
        endcase
        prod_next = PROD_BITS'(amp) * PROD_BITS'(op);
    end

    always_comb begin
        sin_x   = 31'(prod1_reg) + 31'(HALF_FS);
        sin_q   = (32'(sin_x) + 32'(sin_x >> 15) + 32'd1) >> 15;
        mag     = $signed({1'b0, sin_q[15:0]});
        amp_s   = $signed({2'b00, amp});
        saw_sum = {1'b0, prod1_reg} + SAW_RND;
        saw_q   = saw_sum >> (PHASE_BITS - 1);
        tri_sum = {1'b0, prod1_reg} + TRI_RND;
        tri_q   = tri_sum >> (PHASE_BITS - 2);
        case (mode)
            MODE_SINE:     smp = flags1_reg.neg ? -mag : mag;
            MODE_SQUARE:   smp = msb1_reg ? -amp_s : amp_s;
            MODE_SAW:      smp = $signed(saw_q[16:0]) - amp_s;
            MODE_TRIANGLE: smp = $signed(tri_q[16:0]) - amp_s;
            MODE_IMPULSE:  smp = flags1_reg.cnt_zero ? amp_s : '0;
            default:       smp = '0;
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= v0;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            prod1_reg  <= prod_next;
            msb1_reg   <= p0[PHASE_BITS-1];
            flags1_reg <= flags0;
            sample_reg <= smp[SAMPLE_BITS-1:0];
            last_reg   <= flags1_reg.last;
        end
    end

    assign m_valid  = v2_reg;
    assign m_sample = sample_reg;
    assign m_last   = last_reg;

endmodule

// ----- sv/waveform_generator.sv -----
// waveform generator top level: configuration registers, input stage and table ram
//
// each item accepted on the s_ channel (restart, final_tick) yields exactly one item
// on the m_ channel: a signed 16-bit sample of the selected waveform taken at the
// current phase, with last echoing final_tick. after the sample the phase advances
// by the tuning word and the impulse counter steps, wrapping at the period.
// restart clears phase and counter before its own sample is taken.
// configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wr_data), and
// is expected only while no item is in flight.
// an accepted item passes three register stages before m_valid rises: table read,
// amplitude multiply, waveform select into the output register. one item per cycle
// is sustained while m_ready stays high, set by the one multiplier stage and ram read port.
// after reset the quarter sine table is loaded into ram, one entry per cycle;
// s_ready stays low until the last entry has been written, while configuration
// writes are taken as usual.
// when the receiver stalls, the whole pipeline holds and s_ready drops in the
// same cycle; a waiting result is kept until it is taken.
module waveform_generator #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [wg_pkg::IDX_BITS-1:0]     cfg_index,
    input  logic [wg_pkg::CFG_BITS-1:0]     cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_restart,
    input  logic                            s_final_tick,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [wg_pkg::SAMPLE_BITS-1:0] m_sample,
    output logic                            m_last
);
    import wg_pkg::*;

    localparam int DEPTH = 1 << TABLE_ADDR_BITS;

    logic [MODE_BITS-1:0]   mode_reg;
    logic [INC_BITS-1:0]    inc_reg;
    logic [AMP_BITS-1:0]    amp_reg;
    logic [PERIOD_BITS-1:0] period_reg;

    logic                       init_done;
    logic                       ram_we;
    logic [TABLE_ADDR_BITS-1:0] ram_waddr;
    logic [TBL_BITS-1:0]        ram_wdata;
    logic [TABLE_ADDR_BITS-1:0] ram_raddr;
    logic [TBL_BITS-1:0]        ram_rdata;

    logic                       adv;
    logic                       accept;
    logic [PHASE_BITS-1:0]      phase;
    logic                       cnt_zero;
    logic [TABLE_ADDR_BITS-1:0] k;
    wg_flags_t                  flags_next;

    logic                       v0_reg;
    logic [PHASE_BITS-1:0]      p0_reg;
    wg_flags_t                  flags0_reg;
    logic [SAMPLE_BITS-1:0]     sample_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_SINE;
            inc_reg    <= '0;
            amp_reg    <= '0;
            period_reg <= PERIOD_BITS'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_wr_data[MODE_BITS-1:0];
                REG_INC:    inc_reg    <= cfg_wr_data[INC_BITS-1:0];
                REG_AMP:    amp_reg    <= cfg_wr_data[AMP_BITS-1:0];
                REG_PERIOD: period_reg <= cfg_wr_data[PERIOD_BITS-1:0];
                default:    ;
            endcase
        end
    end

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv && init_done;
    assign accept  = s_valid && s_ready;

    wg_tbl_init #(
        .ADDR_BITS (TABLE_ADDR_BITS)
    ) u_tbl_init (
        .clk   (aclk),
        .rstn  (aresetn),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .done  (init_done)
    );

    wg_nco #(
        .PHASE_BITS (PHASE_BITS)
    ) u_nco (
        .clk      (aclk),
        .rstn     (aresetn),
        .accept   (accept),
        .restart  (s_restart),
        .inc      (inc_reg),
        .period   (period_reg),
        .phase    (phase),
        .cnt_zero (cnt_zero)
    );

    // odd quadrants read the table mirrored
    always_comb begin
        k                   = phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
        ram_raddr           = phase[PHASE_BITS-2] ? ('0 - k) : k;
        flags_next.peak     = phase[PHASE_BITS-2] && (k == '0);
        flags_next.neg      = phase[PHASE_BITS-1];
        flags_next.cnt_zero = cnt_zero;
        flags_next.last     = s_final_tick;
    end

    wg_ram #(
        .WIDTH (TBL_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (adv),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p0_reg     <= phase;
            flags0_reg <= flags_next;
        end
    end

    wg_shape #(
        .PHASE_BITS (PHASE_BITS)
    ) u_shape (
        .clk      (aclk),
        .rstn     (aresetn),
        .adv      (adv),
        .v0       (v0_reg),
        .p0       (p0_reg),
        .flags0   (flags0_reg),
        .rdata    (ram_rdata),
        .mode     (mode_reg),
        .amp      (amp_reg),
        .m_valid  (m_valid),
        .m_sample (sample_w),
        .m_last   (m_last)
    );

    assign m_sample = $signed(sample_w);

    a_no_accept_during_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> init_done)
        else $error("item accepted while sine table still loading");

    a_sample_within_amp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_sample <= $signed({1'b0, amp_reg}))
                 && (m_sample >= -$signed({1'b0, amp_reg})))
        else $error("sample magnitude exceeds amplitude");

    a_impulse_levels: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (mode_reg == MODE_IMPULSE))
            |-> (m_sample == '0) || (m_sample == $signed({1'b0, amp_reg})))
        else $error("impulse sample is neither zero nor amplitude");

endmodule
